@@ rtl/bps_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// bps_pkg
// Shared widths, register indexes, codes and control structs of the
// bilinear point sampler.
// -----------------------------------------------------------------------------
package bps_pkg;

	localparam int ADDR_W    = 16;
	localparam int PIX_IN_W  = 16;
	localparam int COORD_W   = 17;
	localparam int OUT_W     = 24;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 4;

	localparam logic [OUT_W-1:0] OUT_MAX     = '1;
	localparam logic [CFG_W-1:0] RST_EXTENT  = 9'd256;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 4'd1;

	// item function codes
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// neighbor slots: near/far x, near/far y
	localparam logic [1:0] NB_X0Y0 = 2'd0;
	localparam logic [1:0] NB_X1Y0 = 2'd1;
	localparam logic [1:0] NB_X0Y1 = 2'd2;
	localparam logic [1:0] NB_X1Y1 = 2'd3;

	typedef struct packed {
		logic       wr_en;     // pixel write at the request address
		logic       load_pt;   // register the decoded sample point
		logic       load_base; // register the two row base addresses
		logic       rd_en;     // pixel read of slot rd_sel
		logic [1:0] rd_sel;
		logic       cap_en;    // capture read data into slot cap_sel
		logic [1:0] cap_sel;
		logic       mix_x;     // blend along x
		logic       mix_y;     // blend along y
		logic       load_out;  // round and load the result register
	} bps_cmd_t;

	typedef struct packed {
		logic outside;
	} bps_sts_t;

endpackage
`default_nettype wire

@@ rtl/bps_if.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// bps_if
// Valid/ready channels of the bilinear point sampler: request items,
// result items and configuration writes.
// -----------------------------------------------------------------------------
interface bps_req_if import bps_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                func;
	logic [ADDR_W-1:0]   pixel_address;
	logic [PIX_IN_W-1:0] pixel_value;
	logic [COORD_W-1:0]  x_coord;
	logic [COORD_W-1:0]  y_coord;
	logic                last_point;

	modport source (output valid, func, pixel_address, pixel_value, x_coord, y_coord,
		last_point, input ready);
	modport sink (input valid, func, pixel_address, pixel_value, x_coord, y_coord,
		last_point, output ready);
endinterface

interface bps_rsp_if import bps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] sample_value;
	logic             outside;
	logic             batch_end;

	modport source (output valid, sample_value, outside, batch_end, input ready);
	modport sink (input valid, sample_value, outside, batch_end, output ready);
endinterface

interface bps_cfg_if import bps_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] idx;
	logic [CFG_W-1:0]     data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface
`default_nettype wire

@@ rtl/bps_ram.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// bps_ram
// Single-port RAM with registered read data.
// -----------------------------------------------------------------------------
module bps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/bps_ctrl.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// bps_ctrl
// Sequencer of the sampler: decodes requests, steps the four neighbor
// reads and the two blend steps, and owns the result handshake.
// -----------------------------------------------------------------------------
module bps_ctrl import bps_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_func,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire bps_sts_t sts,
	output bps_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_BASE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_MIXX  = 3'd4;
	localparam logic [2:0] S_MIXY  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q, state_d;
	logic [1:0] cnt_q, cnt_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_func == FUNC_WRITE) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.load_pt = 1'b1;
						state_d     = S_BASE;
					end
				end
			end
			S_BASE: begin
				cmd.load_base = 1'b1;
				cnt_d         = '0;
				// skip the reads for a point off the image
				state_d       = sts.outside ? S_FIN : S_READ;
			end
			S_READ: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = cnt_q;
				cmd.cap_en  = (cnt_q != NB_X0Y0);
				cmd.cap_sel = cnt_q - 2'd1;
				cnt_d       = cnt_q + 2'd1;
				if (cnt_q == NB_X1Y1) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = NB_X1Y1;
				state_d     = S_MIXX;
			end
			S_MIXX: begin
				cmd.mix_x = 1'b1;
				state_d   = S_MIXY;
			end
			S_MIXY: begin
				cmd.mix_y = 1'b1;
				state_d   = S_FIN;
			end
			S_FIN: begin
				// hold until the result register can take the new value
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= cmd.load_out || (out_valid_q && !out_ready);
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before transfer");

	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_func == FUNC_SAMPLE) |=> (state_q == S_BASE))
		else $error("accepted sample did not start");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.rd_en))
		else $error("pixel read and write in one cycle");

	a_reads_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && cnt_q == NB_X1Y1) |=> (state_q == S_DRAIN))
		else $error("read sequence did not end after four reads");

endmodule
`default_nettype wire

@@ rtl/bps_dp.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// bps_dp
// Datapath of the sampler: extent registers, point decode, neighbor
// addressing, pixel store, blend arithmetic and the result register.
// -----------------------------------------------------------------------------
module bps_dp import bps_pkg::*; #(
	parameter int ROW_LIMIT  = 256,
	parameter int COL_LIMIT  = 256,
	parameter int PIXEL_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bps_cmd_t             cmd,
	output bps_sts_t                  sts,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic [ADDR_W-1:0]    pixel_address,
	input  wire logic [PIX_IN_W-1:0]  pixel_value,
	input  wire logic [COORD_W-1:0]   x_coord,
	input  wire logic [COORD_W-1:0]   y_coord,
	input  wire logic                 last_point,
	output logic      [OUT_W-1:0]     sample_value,
	output logic                      outside,
	output logic                      batch_end
);

	localparam int RW = ($clog2(ROW_LIMIT + 1) > CFG_W) ? $clog2(ROW_LIMIT + 1) : CFG_W;
	localparam int CH = ($clog2(COL_LIMIT + 1) > CFG_W) ? $clog2(COL_LIMIT + 1) : CFG_W;
	localparam int IW = COORD_W - FRAC_BITS;
	localparam int XW = (IW > RW) ? IW : RW;
	localparam int YW = (IW > CH) ? IW : CH;
	localparam int PW = CH + RW;
	localparam int WW = FRAC_BITS + 1;
	localparam int TW = PIXEL_BITS + FRAC_BITS + 1;
	localparam int FW = PIXEL_BITS + 2 * FRAC_BITS + 1;
	localparam int VW = FW + 1 - FRAC_BITS;
	localparam int SW = (VW > OUT_W) ? VW : OUT_W;

	localparam logic [COORD_W:0] COORD_ONE = {{COORD_W{1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [WW-1:0]    W_ONE     = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [FW:0]      HALF      =
		{{(FW + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

	logic [CFG_W-1:0] rows_q, cols_q;
	logic [RW-1:0]    rows_eff;
	logic [CH-1:0]    cols_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RST_EXTENT;
			cols_q <= RST_EXTENT;
		end else if (cfg_valid) begin
			case (cfg_idx)
				REG_ROWS: rows_q <= cfg_data;
				REG_COLS: cols_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	assign rows_eff = (RW'(rows_q) < RW'(ROW_LIMIT)) ? RW'(rows_q) : RW'(ROW_LIMIT);
	assign cols_eff = (CH'(cols_q) < CH'(COL_LIMIT)) ? CH'(cols_q) : CH'(COL_LIMIT);

	// point decode: shift to 0-based, split into floor and fraction
	logic [COORD_W:0]     xr, yr;
	logic [IW-1:0]        xi, yi;
	logic                 pt_out;
	logic [RW-1:0]        x0, x1;
	logic [RW:0]          x0p1;
	logic [CH-1:0]        y0, y1;
	logic [CH:0]          y0p1;

	assign xr     = {x_coord[COORD_W-1], x_coord} - COORD_ONE;
	assign yr     = {y_coord[COORD_W-1], y_coord} - COORD_ONE;
	assign xi     = xr[COORD_W-1:FRAC_BITS];
	assign yi     = yr[COORD_W-1:FRAC_BITS];
	assign pt_out = xr[COORD_W] || yr[COORD_W] ||
		(XW'(xi) >= XW'(rows_eff)) || (YW'(yi) >= YW'(cols_eff));
	assign x0     = RW'(xi);
	assign y0     = CH'(yi);
	assign x0p1   = {1'b0, x0} + (RW + 1)'(1);
	assign y0p1   = {1'b0, y0} + (CH + 1)'(1);
	// clamp the far neighbor to the last column or row
	assign x1     = (x0p1 >= {1'b0, rows_eff}) ? x0 : RW'(x0p1);
	assign y1     = (y0p1 >= {1'b0, cols_eff}) ? y0 : CH'(y0p1);

	logic [RW-1:0]        x0_q, x1_q;
	logic [CH-1:0]        y0_q, y1_q;
	logic [FRAC_BITS-1:0] fx_q, fy_q;
	logic                 out_pt_q, last_q;

	always_ff @(posedge clk) begin
		if (cmd.load_pt) begin
			x0_q     <= x0;
			x1_q     <= x1;
			y0_q     <= y0;
			y1_q     <= y1;
			fx_q     <= xr[FRAC_BITS-1:0];
			fy_q     <= yr[FRAC_BITS-1:0];
			out_pt_q <= pt_out;
			last_q   <= last_point;
		end
	end

	assign sts.outside = out_pt_q;

	// row base addresses, wrapped to the store size
	logic [PW-1:0]     prod0, prod1;
	logic [ADDR_W-1:0] base0_q, base1_q;

	assign prod0 = PW'(y0_q) * PW'(rows_eff);
	assign prod1 = PW'(y1_q) * PW'(rows_eff);

	always_ff @(posedge clk) begin
		if (cmd.load_base) begin
			base0_q <= ADDR_W'(prod0);
			base1_q <= ADDR_W'(prod1);
		end
	end

	logic [ADDR_W-1:0]     rd_addr, ram_addr;
	logic [PIXEL_BITS-1:0] ram_rdata;

	always_comb begin
		case (cmd.rd_sel)
			NB_X0Y0: rd_addr = base0_q + ADDR_W'(x0_q);
			NB_X1Y0: rd_addr = base0_q + ADDR_W'(x1_q);
			NB_X0Y1: rd_addr = base1_q + ADDR_W'(x0_q);
			NB_X1Y1: rd_addr = base1_q + ADDR_W'(x1_q);
			default: rd_addr = base0_q;
		endcase
	end

	assign ram_addr = cmd.wr_en ? pixel_address : rd_addr;

	bps_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (2 ** ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (cmd.wr_en),
		.addr  (ram_addr),
		.wdata (PIXEL_BITS'(pixel_value)),
		.rdata (ram_rdata)
	);

	logic [PIXEL_BITS-1:0] pix_q [4];

	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			pix_q[cmd.cap_sel] <= ram_rdata;
		end
	end

	// blend: along x for both rows, then along y
	logic [WW-1:0] wx, wy;
	logic [TW-1:0] top_q, bot_q;
	logic [FW-1:0] full_q;

	assign wx = W_ONE - {1'b0, fx_q};
	assign wy = W_ONE - {1'b0, fy_q};

	always_ff @(posedge clk) begin
		if (cmd.mix_x) begin
			top_q <= TW'(wx) * TW'(pix_q[NB_X0Y0]) + TW'(fx_q) * TW'(pix_q[NB_X1Y0]);
			bot_q <= TW'(wx) * TW'(pix_q[NB_X0Y1]) + TW'(fx_q) * TW'(pix_q[NB_X1Y1]);
		end
		if (cmd.mix_y) begin
			full_q <= FW'(wy) * FW'(top_q) + FW'(fy_q) * FW'(bot_q);
		end
	end

	// round half up, drop the extra fraction bits, saturate
	logic [FW:0]      rnd;
	logic [VW-1:0]    val;
	logic [OUT_W-1:0] sat;

	assign rnd = {1'b0, full_q} + HALF;
	assign val = rnd[FW:FRAC_BITS];
	assign sat = (SW'(val) > SW'(OUT_MAX)) ? OUT_MAX : OUT_W'(val);

	logic [OUT_W-1:0] value_q;
	logic             outside_q, batch_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			value_q   <= out_pt_q ? '0 : sat;
			outside_q <= out_pt_q;
			batch_q   <= last_q;
		end
	end

	assign sample_value = value_q;
	assign outside      = outside_q;
	assign batch_end    = batch_q;

endmodule
`default_nettype wire

@@ rtl/bilinear_point_sampler_core.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// bilinear_point_sampler_core
// Pixel store with bilinear point sampling: write items load pixels,
// sample items return the blend of the four pixels around a point.
// -----------------------------------------------------------------------------
//   channel  role    payload
//   req      sink    func, pixel_address, pixel_value, x_coord, y_coord, last_point
//   rsp      source  sample_value, outside, batch_end
//   cfg      sink    idx (0 rows_in_use, 1 cols_in_use), data
//
// A write item is done in the idle state. A sample item inside the image
// steps through base, four neighbor reads via the single store port, drain,
// x blend, y blend and final; outside the image it goes from base to final.
// The pixel store has no reset; the user reads it only after it was written,
// which the block does not enforce. Reset sets both extents to 256. A
// stalled result waits in its register while the next item is taken.
// -----------------------------------------------------------------------------
module bilinear_point_sampler_core import bps_pkg::*; #(
	parameter int ROW_LIMIT  = 256,
	parameter int COL_LIMIT  = 256,
	parameter int PIXEL_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bps_req_if.sink   req,
	bps_rsp_if.source rsp,
	bps_cfg_if.sink   cfg
);

	bps_cmd_t cmd;
	bps_sts_t sts;
	logic     in_ready;
	logic     out_valid;

	bps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_func   (req.func),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bps_dp #(
		.ROW_LIMIT  (ROW_LIMIT),
		.COL_LIMIT  (COL_LIMIT),
		.PIXEL_BITS (PIXEL_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_valid     (cfg.valid),
		.cfg_idx       (cfg.idx),
		.cfg_data      (cfg.data),
		.pixel_address (req.pixel_address),
		.pixel_value   (req.pixel_value),
		.x_coord       (req.x_coord),
		.y_coord       (req.y_coord),
		.last_point    (req.last_point),
		.sample_value  (rsp.sample_value),
		.outside       (rsp.outside),
		.batch_end     (rsp.batch_end)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;
	// the user changes extents only while idle (the block does not enforce it); a write is always taken
	assign cfg.ready = 1'b1;

endmodule
`default_nettype wire
